### sv/thbf_pkg.sv
// Shared constants, types and slot tables for the turbo and hold button filter.
package thbf_pkg;

  // Item and register widths.
  localparam int BUTTON_BITS   = 32;
  localparam int TIME_BITS     = 48;
  localparam int SLOTS         = 12;
  localparam int DELAY_BITS    = 10;
  localparam int SLOTS_PER_REG = 6;
  localparam int CFG_BITS      = SLOTS_PER_REG * DELAY_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int POS_BITS      = $clog2(BUTTON_BITS);
  localparam int IN_DATA_BITS  = BUTTON_BITS + TIME_BITS;
  localparam int IN_USER_BITS  = 2;

  // Microseconds per millisecond; the threshold width assumes it stays below 1024.
  localparam int US_PER_MS   = 1000;
  localparam int THRESH_BITS = DELAY_BITS + 10;

  // Bit position of each slot's button inside the button word.
  localparam logic [POS_BITS-1:0] SLOT_POS [SLOTS] = '{
    5'd0, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd12, 5'd13, 5'd14, 5'd15
  };

  // Bits of tuser on the input side.
  localparam int USER_UPDATE = 0;
  localparam int USER_BYPASS = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RAPID_MASK    = 3'd0,
    REG_HOLD_MASK     = 3'd1,
    REG_AUTORUN_MASK  = 3'd2,
    REG_PRESS_LOW     = 3'd3,
    REG_PRESS_HIGH    = 3'd4,
    REG_RELEASE_LOW   = 3'd5,
    REG_RELEASE_HIGH  = 3'd6
  } cfg_reg_t;

  // Per-slot settings seen by one lane.
  typedef struct packed {
    logic                  hold;
    logic                  rapid;
    logic                  autorun;
    logic [DELAY_BITS-1:0] press_limit;
    logic [DELAY_BITS-1:0] release_limit;
  } lane_cfg_t;

  // Per-slot flags kept between items.
  typedef struct packed {
    logic latched;
    logic down;
    logic phase;
  } lane_state_t;

  // What one lane reports for the current item.
  typedef struct packed {
    lane_state_t state;
    logic        out_bit;
    logic        toggle;
  } lane_res_t;

endpackage

### sv/thbf_lane.sv
// One button slot: hold latch, autorun inversion and rapid-fire phase logic.
module thbf_lane (
  input  thbf_pkg::lane_cfg_t                 cfg,
  input  thbf_pkg::lane_state_t               state,
  input  logic                                word_bit,
  input  logic                                is_update,
  input  logic [thbf_pkg::TIME_BITS-1:0]      elapsed_us,
  output thbf_pkg::lane_res_t                 res
);

  logic [thbf_pkg::DELAY_BITS-1:0]  limit;
  logic [thbf_pkg::THRESH_BITS-1:0] thresh;
  logic                             far_past;
  logic                             expired;
  logic                             latched_next;
  logic                             phase_next;

  // Elapsed ms exceeds the limit exactly when elapsed us reaches (limit + 1) * 1000.
  assign limit    = state.phase ? cfg.press_limit : cfg.release_limit;
  assign thresh   = thbf_pkg::THRESH_BITS'(
                      (thbf_pkg::THRESH_BITS'(limit) + thbf_pkg::THRESH_BITS'(1))
                      * thbf_pkg::THRESH_BITS'(thbf_pkg::US_PER_MS));
  assign far_past = |elapsed_us[thbf_pkg::TIME_BITS-1:thbf_pkg::THRESH_BITS];
  assign expired  = far_past || (elapsed_us[thbf_pkg::THRESH_BITS-1:0] >= thresh);

  assign latched_next = state.latched ^ (word_bit & ~state.down);
  assign phase_next   = state.phase ^ (is_update & expired);

  // Hold wins over rapid; a slot in neither mode passes its bit through.
  always_comb begin
    res.state   = state;
    res.out_bit = word_bit;
    res.toggle  = 1'b0;
    if (cfg.hold) begin
      if (cfg.autorun) begin
        res.out_bit = ~word_bit;
      end else begin
        // A press toggles the latch once; while held and unlatched the bit reads released.
        res.state.latched = latched_next;
        res.state.down    = word_bit;
        res.out_bit       = latched_next;
      end
    end else if (cfg.rapid) begin
      res.toggle      = is_update & expired;
      res.state.phase = phase_next;
      if (cfg.autorun || word_bit) begin
        res.out_bit = phase_next;
      end
    end
  end

endmodule

### sv/thbf_merge.sv
// Combines the lane results into the output button word and the shared toggle flag.
module thbf_merge (
  input  logic [thbf_pkg::BUTTON_BITS-1:0]            raw_word,
  input  logic                                        bypass,
  input  thbf_pkg::lane_res_t [thbf_pkg::SLOTS-1:0]   res,
  output logic [thbf_pkg::BUTTON_BITS-1:0]            out_word,
  output logic                                        any_toggle
);

  logic [thbf_pkg::BUTTON_BITS-1:0] lane_word;
  logic [thbf_pkg::SLOTS-1:0]       toggles;

  // Each lane owns one fixed bit of the word; every other bit passes unchanged.
  always_comb begin
    lane_word = raw_word;
    for (int s = 0; s < thbf_pkg::SLOTS; s++) begin
      lane_word[thbf_pkg::SLOT_POS[s]] = res[s].out_bit;
      toggles[s] = res[s].toggle;
    end
  end

  assign out_word   = bypass ? raw_word : lane_word;
  assign any_toggle = ~bypass & (|toggles);

endmodule

### sv/turbo_and_hold_button_filter_unit.sv
// Top level of the turbo and hold button filter: registers, slot lanes and output buffer.
//
//  channel  | group    | payload (low bit first)                        | accepted when
//  ---------+----------+------------------------------------------------+----------------------
//  input    | s_axis_* | tdata: pad_buttons, now_us; tuser: is_update,  | s_axis_tvalid & tready
//           |          |   bypass                                       |
//  output   | m_axis_* | tdata: out_buttons                             | m_axis_tvalid & tready
//  config   | cfg_*    | cfg_index, cfg_data                            | cfg_valid & cfg_ready
//
// An item is accepted every cycle while the skid register is empty; its result is registered in the output buffer.
// All twelve slot lanes and the shared elapsed-time subtract settle in the accept cycle.
// A two-entry output buffer keeps the input open for one item while a result is stalled.
// rst is synchronous: it clears the registers, the slot flags and the buffer.
// A configuration write to a known index clears every slot flag; the toggle timestamp is kept.
module turbo_and_hold_button_filter_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [thbf_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // pad_buttons, now_us
  input  logic [thbf_pkg::IN_USER_BITS-1:0]      s_axis_tuser,  // is_update, bypass
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [thbf_pkg::BUTTON_BITS-1:0]       m_axis_tdata,  // out_buttons
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [thbf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [thbf_pkg::CFG_BITS-1:0]          cfg_data
);

  // Configuration registers.
  logic [thbf_pkg::SLOTS-1:0]    rapid_mask;
  logic [thbf_pkg::SLOTS-1:0]    hold_mask;
  logic [thbf_pkg::SLOTS-1:0]    autorun_mask;
  logic [thbf_pkg::CFG_BITS-1:0] press_low;
  logic [thbf_pkg::CFG_BITS-1:0] press_high;
  logic [thbf_pkg::CFG_BITS-1:0] release_low;
  logic [thbf_pkg::CFG_BITS-1:0] release_high;

  // Filter state.
  logic [thbf_pkg::TIME_BITS-1:0] last_toggle_time;
  logic [thbf_pkg::SLOTS-1:0]     hold_latched;
  logic [thbf_pkg::SLOTS-1:0]     hold_down;
  logic [thbf_pkg::SLOTS-1:0]     press_phase;

  // Output buffer: head register and skid register.
  logic                            out_valid;
  logic [thbf_pkg::BUTTON_BITS-1:0] out_data;
  logic                            skid_valid;
  logic [thbf_pkg::BUTTON_BITS-1:0] skid_data;

  logic                             in_accept;
  logic                             out_pop;
  logic                             cfg_write;
  logic                             cfg_known;
  logic [thbf_pkg::BUTTON_BITS-1:0] pad_buttons;
  logic [thbf_pkg::TIME_BITS-1:0]   now_us;
  logic                             is_update;
  logic                             bypass;
  logic [thbf_pkg::TIME_BITS-1:0]   elapsed_us;
  logic [thbf_pkg::BUTTON_BITS-1:0] result_word;
  logic                             any_toggle;

  thbf_pkg::lane_cfg_t   [thbf_pkg::SLOTS-1:0] lane_cfg;
  thbf_pkg::lane_state_t [thbf_pkg::SLOTS-1:0] lane_state;
  thbf_pkg::lane_res_t   [thbf_pkg::SLOTS-1:0] lane_res;

  // Unpack the input item.
  assign pad_buttons = s_axis_tdata[thbf_pkg::BUTTON_BITS-1:0];
  assign now_us      = s_axis_tdata[thbf_pkg::IN_DATA_BITS-1:thbf_pkg::BUTTON_BITS];
  assign is_update   = s_axis_tuser[thbf_pkg::USER_UPDATE];
  assign bypass      = s_axis_tuser[thbf_pkg::USER_BYPASS];

  // Handshakes.
  assign s_axis_tready = ~skid_valid;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_pop       = out_valid & m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid & cfg_ready;

  // Time since the shared last toggle, modulo the timestamp width.
  assign elapsed_us = now_us - last_toggle_time;

  // Slot lanes.
  for (genvar s = 0; s < thbf_pkg::SLOTS; s++) begin : g_lane
    assign lane_cfg[s].hold    = hold_mask[s];
    assign lane_cfg[s].rapid   = rapid_mask[s];
    assign lane_cfg[s].autorun = autorun_mask[s];
    if (s < thbf_pkg::SLOTS_PER_REG) begin : g_low
      assign lane_cfg[s].press_limit   = press_low[s*thbf_pkg::DELAY_BITS +: thbf_pkg::DELAY_BITS];
      assign lane_cfg[s].release_limit =
        release_low[s*thbf_pkg::DELAY_BITS +: thbf_pkg::DELAY_BITS];
    end else begin : g_high
      assign lane_cfg[s].press_limit =
        press_high[(s-thbf_pkg::SLOTS_PER_REG)*thbf_pkg::DELAY_BITS +: thbf_pkg::DELAY_BITS];
      assign lane_cfg[s].release_limit =
        release_high[(s-thbf_pkg::SLOTS_PER_REG)*thbf_pkg::DELAY_BITS +: thbf_pkg::DELAY_BITS];
    end
    assign lane_state[s].latched = hold_latched[s];
    assign lane_state[s].down    = hold_down[s];
    assign lane_state[s].phase   = press_phase[s];

    thbf_lane u_lane (
      .cfg        (lane_cfg[s]),
      .state      (lane_state[s]),
      .word_bit   (pad_buttons[thbf_pkg::SLOT_POS[s]]),
      .is_update  (is_update),
      .elapsed_us (elapsed_us),
      .res        (lane_res[s])
    );
  end

  thbf_merge u_merge (
    .raw_word   (pad_buttons),
    .bypass     (bypass),
    .res        (lane_res),
    .out_word   (result_word),
    .any_toggle (any_toggle)
  );

  // Decode of the configuration index; unknown indexes are ignored.
  always_comb begin
    unique case (thbf_pkg::cfg_reg_t'(cfg_index)) inside
      thbf_pkg::REG_RAPID_MASK, thbf_pkg::REG_HOLD_MASK, thbf_pkg::REG_AUTORUN_MASK,
      thbf_pkg::REG_PRESS_LOW, thbf_pkg::REG_PRESS_HIGH, thbf_pkg::REG_RELEASE_LOW,
      thbf_pkg::REG_RELEASE_HIGH: cfg_known = 1'b1;
      default:                    cfg_known = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rapid_mask   <= '0;
      hold_mask    <= '0;
      autorun_mask <= '0;
      press_low    <= '0;
      press_high   <= '0;
      release_low  <= '0;
      release_high <= '0;
    end else if (cfg_write) begin
      unique case (thbf_pkg::cfg_reg_t'(cfg_index))
        thbf_pkg::REG_RAPID_MASK:   rapid_mask   <= cfg_data[thbf_pkg::SLOTS-1:0];
        thbf_pkg::REG_HOLD_MASK:    hold_mask    <= cfg_data[thbf_pkg::SLOTS-1:0];
        thbf_pkg::REG_AUTORUN_MASK: autorun_mask <= cfg_data[thbf_pkg::SLOTS-1:0];
        thbf_pkg::REG_PRESS_LOW:    press_low    <= cfg_data;
        thbf_pkg::REG_PRESS_HIGH:   press_high   <= cfg_data;
        thbf_pkg::REG_RELEASE_LOW:  release_low  <= cfg_data;
        thbf_pkg::REG_RELEASE_HIGH: release_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Slot flags and the shared toggle timestamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_toggle_time <= '0;
      hold_latched     <= '0;
      hold_down        <= '0;
      press_phase      <= '0;
    end else if (cfg_write && cfg_known) begin
      hold_latched <= '0;
      hold_down    <= '0;
      press_phase  <= '0;
    end else if (in_accept && !bypass) begin
      for (int s = 0; s < thbf_pkg::SLOTS; s++) begin
        hold_latched[s] <= lane_res[s].state.latched;
        hold_down[s]    <= lane_res[s].state.down;
        press_phase[s]  <= lane_res[s].state.phase;
      end
      if (any_toggle) begin
        last_toggle_time <= now_us;
      end
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_pop) begin
      out_valid  <= skid_valid | in_accept;
      skid_valid <= skid_valid & in_accept;
    end else if (!out_valid) begin
      out_valid <= in_accept;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk) begin
    if (out_pop) begin
      out_data <= skid_valid ? skid_data : result_word;
      if (skid_valid) begin
        skid_data <= result_word;
      end
    end else if (!out_valid) begin
      out_data <= result_word;
    end else if (in_accept) begin
      skid_data <= result_word;
    end
  end

endmodule

### sv/thbf_checker.sv
// Port-level checks for the button filter, bound to the top level.
module thbf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [thbf_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  input logic [thbf_pkg::IN_USER_BITS-1:0]   s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [thbf_pkg::BUTTON_BITS-1:0]    m_axis_tdata
);

  logic take_idle;

  assign take_idle = s_axis_tvalid && s_axis_tready && !m_axis_tvalid;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A bypass item taken with the output empty comes out unchanged next cycle.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    take_idle && s_axis_tuser[thbf_pkg::USER_BYPASS] |=>
      m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata[thbf_pkg::BUTTON_BITS-1:0]))
    else $error("bypass item altered");

  // Bits outside the button slots pass through for an item taken with the output empty.
  a_other_bits: assert property (@(posedge clk) disable iff (rst)
    take_idle |=> m_axis_tvalid
      && m_axis_tdata[2:1] == $past(s_axis_tdata[2:1])
      && m_axis_tdata[11:10] == $past(s_axis_tdata[11:10])
      && m_axis_tdata[31:16] == $past(s_axis_tdata[31:16]))
    else $error("non-slot bit changed");

endmodule

bind turbo_and_hold_button_filter_unit thbf_checker u_thbf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
